// ===== design/dnh_pkg.sv =====
// Package for the directory name hash block: item types, controller
// commands, state codes and constants. Depends on nothing.
package dnh_pkg;

  // Widths of the hash and the table size.
  localparam int unsigned HashW  = 11;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned CountW = 4;

  // One remainder step for each bit of the hash.
  localparam logic [CountW-1:0] HashSteps = CountW'(HashW);

  // Configuration register indexes.
  localparam logic [0:0] RegTableSize = 1'b0;
  localparam logic [0:0] RegIntlMode  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SizeW-1:0] TableSizeReset = 16'd72;

  // Character codes used by the case folding.
  localparam logic [7:0] AsciiLowA   = 8'h61;
  localparam logic [7:0] AsciiLowZ   = 8'h7a;
  localparam logic [7:0] LatinLowLo  = 8'he0;
  localparam logic [7:0] LatinLowHi  = 8'hfe;
  localparam logic [7:0] LatinDivide = 8'hf7;
  localparam logic [7:0] CaseOffset  = 8'h20;

  typedef struct packed {
    logic [7:0] name_byte;
    logic [7:0] name_length;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [SizeW-1:0] bucket;
    logic [HashW-1:0] raw_hash;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input item is taken this cycle
    logic div_step;  // one remainder step
    logic out_load;  // the remainder is final, load the result register
  } dnh_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } dnh_state_e;

endpackage

// ===== design/dnh_ctrl.sv =====
// Controller of the directory name hash block: input and output handshake,
// remainder step counter and result valid flag. Depends on dnh_pkg.
module dnh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dnh_pkg::dnh_cmd_t cmd_o
);
  import dnh_pkg::*;

  dnh_state_e        state_q, state_d;
  logic [CountW-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              in_take;

  // The result register can take a new item when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = in_valid_i && (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take && in_last_i) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if ((step_q == HashSteps) && out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    step_d     = step_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        step_d       = '0;
      end
      S_DIV: begin
        if (step_q != HashSteps) begin
          cmd_o.div_step = 1'b1;
          step_d         = step_q + CountW'(1);
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  // The result stays valid until it is taken.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= HashSteps)
    else $error("remainder step counter ran past the hash width");

  a_load_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (step_q == HashSteps) && (state_q == S_DIV))
    else $error("result loaded before the remainder was complete");

  a_last_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_last_i) |=> (state_q == S_DIV))
    else $error("last item did not start the remainder");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result was dropped");

endmodule

// ===== design/dnh_datapath.sv =====
// Datapath of the directory name hash block: configuration registers,
// running hash, byte count and the bit-serial remainder. Depends on dnh_pkg.
module dnh_datapath #(
  parameter int unsigned NAME_MAX = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dnh_pkg::dnh_cmd_t       cmd_i,
  input  dnh_pkg::in_item_t       in_item_i,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_addr_i,
  input  logic [dnh_pkg::SizeW-1:0] cfg_wdata_i,
  output dnh_pkg::out_item_t      out_item_o
);
  import dnh_pkg::*;

  localparam logic [7:0] NameMax = 8'(NAME_MAX);

  logic [SizeW-1:0] table_size_q;
  logic             intl_mode_q;
  logic [HashW-1:0] hash_q, hash_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       kept_q, kept_d;
  logic [HashW-1:0] shift_q;
  logic [SizeW-1:0] rem_q;
  logic [SizeW:0]   trial;
  logic [SizeW:0]   trial_sub;
  logic [7:0]       folded;
  logic [HashW-1:0] hash_base, hash_mul;
  logic [7:0]       count_base, kept_base;
  out_item_t        out_q;

  // Upper-case folding of one character.
  function automatic logic [7:0] fold(input logic [7:0] c, input logic intl);
    logic lower_ascii;
    logic lower_latin;
    lower_ascii = (c >= AsciiLowA) && (c <= AsciiLowZ);
    lower_latin = intl && (c >= LatinLowLo) && (c <= LatinLowHi) && (c != LatinDivide);
    return (lower_ascii || lower_latin) ? (c - CaseOffset) : c;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeReset;
      intl_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegTableSize: table_size_q <= cfg_wdata_i;
        RegIntlMode:  intl_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A first item restarts the name with the cut length as seed.
  always_comb begin
    if (in_item_i.first) begin
      kept_base  = (in_item_i.name_length > NameMax) ? NameMax : in_item_i.name_length;
      hash_base  = {{(HashW-8){1'b0}}, kept_base};
      count_base = '0;
    end else begin
      kept_base  = kept_q;
      hash_base  = hash_q;
      count_base = count_q;
    end
  end

  // Hash update: times thirteen plus the folded byte, modulo 2048.
  assign folded   = fold(in_item_i.name_byte, intl_mode_q);
  assign hash_mul = (hash_base << 3) + (hash_base << 2) + hash_base;

  always_comb begin
    hash_d  = hash_q;
    count_d = count_q;
    kept_d  = kept_q;
    if (cmd_i.accept) begin
      kept_d  = kept_base;
      hash_d  = hash_base;
      count_d = count_base;
      if (count_base < kept_base) begin
        hash_d  = hash_mul + {{(HashW-8){1'b0}}, folded};
        count_d = count_base + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      count_q <= '0;
      kept_q  <= '0;
    end else begin
      hash_q  <= hash_d;
      count_q <= count_d;
      kept_q  <= kept_d;
    end
  end

  // Restoring remainder, one hash bit per step from the top.
  assign trial     = {rem_q, shift_q[HashW-1]};
  assign trial_sub = trial - {1'b0, table_size_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      shift_q <= hash_d;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      shift_q <= {shift_q[HashW-2:0], 1'b0};
      rem_q   <= (trial >= {1'b0, table_size_q}) ? trial_sub[SizeW-1:0] : trial[SizeW-1:0];
    end
  end

  // Result register; a zero table size gives bucket zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.bucket   <= (table_size_q == '0) ? '0 : rem_q;
      out_q.raw_hash <= hash_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== design/directory_name_hash.sv =====
// Top level of the directory name hash block: joins controller and datapath.
// Depends on dnh_pkg, dnh_ctrl and dnh_datapath.
//
// Takes a name one byte per item, one item per cycle while the input is not
// stalled, and keeps a running eleven-bit hash of the first NAME_MAX bytes
// with case folding. An item marked last is followed by a bit-serial
// remainder of the hash by the table size: the input stalls through the 11
// remainder steps and the load of the result register. The result register
// holds a finished result while the next name is taken; the load of a second
// result waits only if that result is not yet taken. Configuration is written
// through a plain write port at index 0 (table size) and 1 (international
// folding).
module directory_name_hash #(
  parameter int unsigned NAME_MAX = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dnh_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dnh_pkg::out_item_t        out_item_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_addr_i,
  input  logic [dnh_pkg::SizeW-1:0] cfg_wdata_i
);
  import dnh_pkg::*;

  dnh_cmd_t cmd;

  // Sequencing of handshakes and remainder steps.
  dnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  // Hash, remainder and configuration state.
  dnh_datapath #(
    .NAME_MAX(NAME_MAX)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_item_o (out_item_o)
  );

endmodule
